[rtl/analog_input_scaler_defines.svh]
// Assertion macros shared by the analog input scaler RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ANALOG_INPUT_SCALER_DEFINES_SVH
`define ANALOG_INPUT_SCALER_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define AIS_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("analog_input_scaler: invariant violated");

// Check that a condition in one cycle implies another in the next cycle
`define AIS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("analog_input_scaler: next-cycle check violated");

`endif

[rtl/ais_pkg.sv]
// Shared types and constants of the analog input scaler.
// No dependencies; the scaler top, register file and both segments import this package.
`default_nettype none

package ais_pkg;

    // Fixed field widths
    localparam int unsigned RAW_W   = 16;
    localparam int unsigned LEVEL_W = 21;
    localparam int unsigned PARAM_W = 16;
    localparam int unsigned GAIN_W  = 32;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    // Scaling constants
    localparam logic [RAW_W-1:0]   LOW_LEVEL_COUNTS = 16'd1000;
    localparam logic [LEVEL_W-1:0] FOUR_UNITS_Q16   = 21'd262144;
    localparam logic [LEVEL_W-1:0] SIGNAL_MAX       = 21'h1F_FFFF;

    // Register reset values
    localparam logic [15:0] SPAN_LIMIT_RST = 16'd63450;
    localparam logic [15:0] PARAM_MAX_RST  = 16'hFFFF;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_MIN_OFFSET   = 3'd0,
        REG_SPAN_LIMIT   = 3'd1,
        REG_SIGNAL_GAIN  = 3'd2,
        REG_LOOP_CURRENT = 3'd3,
        REG_PARAM_GAIN   = 3'd4,
        REG_PARAM_MIN    = 3'd5,
        REG_PARAM_MAX    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [15:0]       min_offset;
        logic [15:0]       span_limit;
        logic [GAIN_W-1:0] signal_gain;
        logic              loop_current_mode;
        logic [GAIN_W-1:0] param_gain;
        logic [15:0]       param_min;
        logic [15:0]       param_max;
    } t_cfg;

    typedef struct packed {
        logic [RAW_W-1:0] raw_sample;
    } t_sample;

    // Between the signal and parameter segments
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] operand;
    } t_level;

    typedef struct packed {
        logic [LEVEL_W-1:0] signal_level;
        logic [PARAM_W-1:0] param_value;
    } t_result;

endpackage

`default_nettype wire

[rtl/ais_stream_if.sv]
// Valid/ready stream interface used by every channel of the scaler.
// The payload type is set per instance; no other dependencies.
`default_nettype none

interface ais_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/analog_input_scaler.sv]
// An accepted sample passes through the signal segment stages, then the parameter segment stages, to o_result.
// One item per cycle while o_result is not stalled; the stages of both segments set the depth.
// A stalled output fills empty stages first, then holds the input back.
// Reset clears all stage valid bits and loads the register reset values.
// Top level: config registers, signal segment, parameter segment.
`default_nettype none

module analog_input_scaler (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    ais_stream_if.sink                      i_sample,
    ais_stream_if.source                    o_result,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ais_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ais_pkg::DATA_W-1:0] pwdata,
    output logic      [ais_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
    import ais_pkg::*;

    t_cfg cfg;

    ais_stream_if #(.t_payload(t_level)) level_ch ();

    // Hold the configuration
    ais_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Scale counts to the signal level
    ais_signal_seg u_signal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_sample (i_sample),
        .o_level  (level_ch.source)
    );

    // Scale the signal level to the parameter
    ais_param_seg u_param (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_level  (level_ch.sink),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

[rtl/ais_cfg_regs.sv]
// APB-style configuration register file of the scaler.
// Depends on ais_pkg for the register indexes and the t_cfg struct.
`default_nettype none

module ais_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ais_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ais_pkg::DATA_W-1:0] pwdata,
    output logic      [ais_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output ais_pkg::t_cfg                   o_cfg
);
    import ais_pkg::*;

    t_cfg     r_cfg;
    logic     wr_en;
    t_reg_idx idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign o_cfg  = r_cfg;

    // Write on the access phase; ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_offset        <= '0;
            r_cfg.span_limit        <= SPAN_LIMIT_RST;
            r_cfg.signal_gain       <= '0;
            r_cfg.loop_current_mode <= 1'b0;
            r_cfg.param_gain        <= '0;
            r_cfg.param_min         <= '0;
            r_cfg.param_max         <= PARAM_MAX_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_MIN_OFFSET:   r_cfg.min_offset        <= pwdata[15:0];
                REG_SPAN_LIMIT:   r_cfg.span_limit        <= pwdata[15:0];
                REG_SIGNAL_GAIN:  r_cfg.signal_gain       <= pwdata;
                REG_LOOP_CURRENT: r_cfg.loop_current_mode <= pwdata[0];
                REG_PARAM_GAIN:   r_cfg.param_gain        <= pwdata;
                REG_PARAM_MIN:    r_cfg.param_min         <= pwdata[15:0];
                REG_PARAM_MAX:    r_cfg.param_max         <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (idx)
            REG_MIN_OFFSET:   prdata = {16'd0, r_cfg.min_offset};
            REG_SPAN_LIMIT:   prdata = {16'd0, r_cfg.span_limit};
            REG_SIGNAL_GAIN:  prdata = r_cfg.signal_gain;
            REG_LOOP_CURRENT: prdata = {31'd0, r_cfg.loop_current_mode};
            REG_PARAM_GAIN:   prdata = r_cfg.param_gain;
            REG_PARAM_MIN:    prdata = {16'd0, r_cfg.param_min};
            REG_PARAM_MAX:    prdata = {16'd0, r_cfg.param_max};
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/ais_signal_seg.sv]
// Signal path: threshold, offset and clamp, gain multiply, saturation, loop current offset.
// Depends on ais_pkg and ais_stream_if; three register stages.
`default_nettype none
`include "analog_input_scaler_defines.svh"

module ais_signal_seg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  ais_pkg::t_cfg      i_cfg,
    ais_stream_if.sink         i_sample,
    ais_stream_if.source       o_level
);
    import ais_pkg::*;

    localparam int unsigned PROD_W = RAW_W + GAIN_W;

    logic [2:0]           r_v;
    logic [2:0]           en;
    logic [RAW_W-1:0]     r_cnt;
    logic [PROD_W-1:0]    r_prod;
    logic [LEVEL_W-1:0]   r_level;
    logic [LEVEL_W-1:0]   r_oper;
    logic [RAW_W-1:0]     thr;
    logic [RAW_W-1:0]     diff;
    logic [RAW_W-1:0]     n_cnt;
    logic [LEVEL_W-1:0]   n_level;
    logic [LEVEL_W-1:0]   n_oper;

    // A stage advances when it is empty or the one after it advances
    assign en[2]          = !r_v[2] || o_level.ready;
    assign en[1]          = !r_v[1] || en[2];
    assign en[0]          = !r_v[0] || en[1];
    assign i_sample.ready = en[0];

    // Stage 0: drop low samples, subtract offset, clamp to span
    always_comb begin
        thr   = (i_sample.data.raw_sample > LOW_LEVEL_COUNTS) ?
                i_sample.data.raw_sample : '0;
        diff  = (thr > i_cfg.min_offset) ? (thr - i_cfg.min_offset) : '0;
        n_cnt = (diff > i_cfg.span_limit) ? i_cfg.span_limit : diff;
    end

    // Stage 2: saturate to Q5.16, take 4.0 off in loop current mode
    always_comb begin
        n_level = (|r_prod[PROD_W-1:LEVEL_W+16]) ? SIGNAL_MAX :
                  r_prod[LEVEL_W+15:16];
        if (i_cfg.loop_current_mode) begin
            n_oper = (n_level > FOUR_UNITS_Q16) ? (n_level - FOUR_UNITS_Q16) : '0;
        end else begin
            n_oper = n_level;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_sample.valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (en[0]) r_cnt  <= n_cnt;
        if (en[1]) r_prod <= PROD_W'(r_cnt) * PROD_W'(i_cfg.signal_gain);
        if (en[2]) begin
            r_level <= n_level;
            r_oper  <= n_oper;
        end
    end

    assign o_level.valid        = r_v[2];
    assign o_level.data.level   = r_level;
    assign o_level.data.operand = r_oper;

    `AIS_ASSERT(a_cnt_in_span, n_cnt <= i_cfg.span_limit)
    `AIS_ASSERT(a_oper_not_above_level, !r_v[2] || (r_oper <= r_level))
    `AIS_ASSERT_NEXT(a_level_hold, o_level.valid && !o_level.ready,
        o_level.valid && $stable(r_level) && $stable(r_oper))

endmodule

`default_nettype wire

[rtl/ais_param_seg.sv]
// Parameter path: gain multiply, offset add, clamp to bounds.
// Depends on ais_pkg and ais_stream_if; two register stages.
`default_nettype none
`include "analog_input_scaler_defines.svh"

module ais_param_seg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  ais_pkg::t_cfg      i_cfg,
    ais_stream_if.sink         i_level,
    ais_stream_if.source       o_result
);
    import ais_pkg::*;

    localparam int unsigned PROD_W = LEVEL_W + GAIN_W;
    localparam int unsigned SUM_W  = LEVEL_W + 1;

    logic [1:0]           r_v;
    logic [1:0]           en;
    logic [LEVEL_W-1:0]   r_lvl0;
    logic [LEVEL_W-1:0]   r_lvl1;
    logic [LEVEL_W-1:0]   r_phi;
    logic [PARAM_W-1:0]   r_param;
    logic [PROD_W-1:0]    prod;
    logic [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]     lo;
    logic [SUM_W-1:0]     n_param;

    // A stage advances when it is empty or the one after it advances
    assign en[1]         = !r_v[1] || o_result.ready;
    assign en[0]         = !r_v[0] || en[1];
    assign i_level.ready = en[0];

    // Stage 0: Q5.16 times Q16.16, keep the integer part
    assign prod = PROD_W'(i_level.data.operand) * PROD_W'(i_cfg.param_gain);

    // Stage 1: add the minimum, clamp low first and high last
    always_comb begin
        sum     = SUM_W'(r_phi) + SUM_W'(i_cfg.param_min);
        lo      = (sum < SUM_W'(i_cfg.param_min)) ? SUM_W'(i_cfg.param_min) : sum;
        n_param = (lo > SUM_W'(i_cfg.param_max)) ? SUM_W'(i_cfg.param_max) : lo;
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_level.valid;
            if (en[1]) r_v[1] <= r_v[0];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_lvl0 <= i_level.data.level;
            r_phi  <= prod[PROD_W-1:GAIN_W];
        end
        if (en[1]) begin
            r_lvl1  <= r_lvl0;
            r_param <= n_param[PARAM_W-1:0];
        end
    end

    assign o_result.valid             = r_v[1];
    assign o_result.data.signal_level = r_lvl1;
    assign o_result.data.param_value  = r_param;

    `AIS_ASSERT(a_param_below_max, !r_v[0] || (n_param <= SUM_W'(i_cfg.param_max)))
    `AIS_ASSERT_NEXT(a_result_hold, o_result.valid && !o_result.ready,
        o_result.valid && $stable(r_lvl1) && $stable(r_param))

endmodule

`default_nettype wire

[sim/tb_analog_input_scaler.sv]
// Self-checking testbench for analog_input_scaler: directed table, then random phases.
// Depends on rtl/ais_pkg.sv, rtl/ais_stream_if.sv and rtl/analog_input_scaler.sv.
`timescale 1ns / 1ps

module tb_analog_input_scaler;
    import ais_pkg::*;

    localparam int PIPE_LATENCY      = 5;
    localparam int WATCHDOG_LIMIT    = 5000;
    localparam int NUM_RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE   = 225;

    // Index past the last register; writes to it must be ignored
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct {
        int               setting;
        logic [RAW_W-1:0] raw;
        bit               typed;
        t_result          result;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    ais_stream_if #(.t_payload(t_sample)) sample_if ();
    ais_stream_if #(.t_payload(t_result)) result_if ();

    analog_input_scaler dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_if.sink),
        .o_result (result_if.source),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    t_cfg    active_cfg;
    t_cfg    setting_table [6];
    t_row    directed_rows [$];
    t_result expected_results [$];
    int      error_count;
    int      src_idle_pct;
    int      snk_stall_pct;
    int      quiet_cycles;

    // Clock: 10 ns period
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Scale one sample under a given register setting
    function automatic t_result predict_scaling(input t_cfg c, input logic [RAW_W-1:0] raw);
        logic [15:0] counts;
        logic [63:0] level;
        logic [63:0] v;
        t_result     r;
        counts = (raw > LOW_LEVEL_COUNTS) ? raw : 16'd0;
        counts = (counts > c.min_offset) ? counts - c.min_offset : 16'd0;
        if (counts > c.span_limit)
            counts = c.span_limit;
        level = (64'(counts) * 64'(c.signal_gain)) >> 16;
        if (level > 64'(SIGNAL_MAX))
            level = 64'(SIGNAL_MAX);
        v = level;
        if (c.loop_current_mode)
            v = (v > 64'(FOUR_UNITS_Q16)) ? v - 64'(FOUR_UNITS_Q16) : 64'd0;
        v = (v * 64'(c.param_gain)) >> 32;
        v = v + 64'(c.param_min);
        // Lower bound first, upper bound last: crossed bounds give param_max
        if (v < 64'(c.param_min))
            v = 64'(c.param_min);
        if (v > 64'(c.param_max))
            v = 64'(c.param_max);
        r.signal_level = level[LEVEL_W-1:0];
        r.param_value  = v[PARAM_W-1:0];
        return r;
    endfunction

    function automatic logic [15:0] pick_half_word();
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom >> $urandom_range(0, 20);
        endcase
    endfunction

    function automatic t_cfg random_setting();
        t_cfg c;
        c.min_offset        = ($urandom_range(0, 2) == 0) ? pick_half_word()
                                                          : 16'($urandom_range(0, 4000));
        c.span_limit        = pick_half_word();
        c.signal_gain       = pick_gain();
        c.loop_current_mode = 1'($urandom);
        c.param_gain        = pick_gain();
        c.param_min         = ($urandom_range(0, 2) == 0) ? pick_half_word()
                                                          : 16'($urandom_range(0, 2000));
        c.param_max         = pick_half_word();
        return c;
    endfunction

    // Bias samples toward the threshold, the offset and the extremes
    function automatic logic [RAW_W-1:0] random_sample();
        int near;
        case ($urandom_range(0, 7))
            0: return 16'($urandom_range(995, 1005));
            1: begin
                near = int'(active_cfg.min_offset) + int'($urandom_range(0, 6)) - 3;
                if (near < 0)
                    near = 0;
                if (near > 65535)
                    near = 65535;
                return 16'(near);
            end
            2: return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void add_row(input int sel, input logic [RAW_W-1:0] raw, input bit typed,
                                    input logic [LEVEL_W-1:0] sig, input logic [PARAM_W-1:0] par);
        t_row row;
        row.setting             = sel;
        row.raw                 = raw;
        row.typed               = typed;
        row.result.signal_level = sig;
        row.result.param_value  = par;
        directed_rows.push_back(row);
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write one register and read it back
    task automatic program_register(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        apb_write(idx, value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== value) begin
            $error("register %0d: expected %h, actual %h", idx, value, prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_setting(input t_cfg c);
        program_register(REG_MIN_OFFSET,   32'(c.min_offset));
        program_register(REG_SPAN_LIMIT,   32'(c.span_limit));
        program_register(REG_SIGNAL_GAIN,  c.signal_gain);
        program_register(REG_LOOP_CURRENT, 32'(c.loop_current_mode));
        program_register(REG_PARAM_GAIN,   c.param_gain);
        program_register(REG_PARAM_MIN,    32'(c.param_min));
        program_register(REG_PARAM_MAX,    32'(c.param_max));
        // Unknown index: the block must keep its registers
        apb_write(REG_UNUSED, $urandom);
        active_cfg = c;
    endtask

    // Drop valid, then hold until every result is back and the pipe is empty
    task automatic wait_idle();
        sample_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Offer one item, idling first at random; record its expected result
    task automatic send_sample(input logic [RAW_W-1:0] raw, input bit typed,
                               input t_result typed_result);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            sample_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        sample_if.valid           <= 1'b1;
        sample_if.data.raw_sample <= raw;
        @(posedge i_clk);
        while (!sample_if.ready) @(posedge i_clk);
        if (typed)
            expected_results.push_back(typed_result);
        else
            expected_results.push_back(predict_scaling(active_cfg, raw));
        @(negedge i_clk);
    endtask

    // Receiver: stall at random
    always @(negedge i_clk) begin
        result_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            got = result_if.data;
            if (expected_results.size() == 0) begin
                $error("unexpected result: signal_level %0d param_value %0d",
                       got.signal_level, got.param_value);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.signal_level !== want.signal_level) begin
                    $error("signal_level: expected %0d, actual %0d",
                           want.signal_level, got.signal_level);
                    error_count++;
                end
                if (got.param_value !== want.param_value) begin
                    $error("param_value: expected %0d, actual %0d",
                           want.param_value, got.param_value);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int      cur_sel;
        int      phase;
        t_result none;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        sample_if.valid = 1'b0;
        sample_if.data  = '0;
        result_if.ready = 1'b0;
        error_count     = 0;
        quiet_cycles    = 0;
        src_idle_pct    = 0;
        snk_stall_pct   = 0;
        none            = '0;

        // Settings: reset values, all maximum, calibrated loop current,
        // crossed bounds with offset above every sample, sum too large, all zero but loop current mode
        setting_table[0] = '{min_offset: 16'd0, span_limit: SPAN_LIMIT_RST, signal_gain: 32'd0,
                             loop_current_mode: 1'b0, param_gain: 32'd0, param_min: 16'd0,
                             param_max: PARAM_MAX_RST};
        setting_table[1] = '{min_offset: 16'd0, span_limit: 16'hFFFF,
                             signal_gain: 32'hFFFF_FFFF, loop_current_mode: 1'b0,
                             param_gain: 32'hFFFF_FFFF, param_min: 16'd0, param_max: 16'hFFFF};
        setting_table[2] = '{min_offset: 16'd5000, span_limit: 16'd40000,
                             signal_gain: 32'd655360, loop_current_mode: 1'b1,
                             param_gain: 32'h0064_0000, param_min: 16'd100,
                             param_max: 16'd50000};
        setting_table[3] = '{min_offset: 16'hFFFF, span_limit: 16'd0,
                             signal_gain: 32'hFFFF_FFFF, loop_current_mode: 1'b1,
                             param_gain: 32'h0001_0000, param_min: 16'd60000,
                             param_max: 16'd1000};
        setting_table[4] = '{min_offset: 16'd0, span_limit: 16'hFFFF,
                             signal_gain: 32'hFFFF_FFFF, loop_current_mode: 1'b0,
                             param_gain: 32'hFFFF_FFFF, param_min: 16'd65000,
                             param_max: 16'hFFFF};
        setting_table[5] = '{min_offset: 16'd0, span_limit: 16'd0, signal_gain: 32'd0,
                             loop_current_mode: 1'b1, param_gain: 32'd0, param_min: 16'd0,
                             param_max: 16'd0};

        // Directed table: setting, sample, typed flag, signal_level, param_value
        add_row(0, 16'd0,     1, 21'd0,      16'd0);
        add_row(0, 16'hFFFF,  1, 21'd0,      16'd0);
        add_row(0, 16'd1000,  1, 21'd0,      16'd0);
        add_row(0, 16'd1001,  0, 21'd0,      16'd0);
        add_row(1, 16'hFFFF,  1, SIGNAL_MAX, 16'hFFFF);
        add_row(1, 16'd1000,  1, 21'd0,      16'd0);
        add_row(1, 16'd0,     1, 21'd0,      16'd0);
        add_row(1, 16'd1001,  0, 21'd0,      16'd0);
        add_row(1, 16'h8000,  0, 21'd0,      16'd0);
        add_row(2, 16'd1001,  0, 21'd0,      16'd0);
        add_row(2, 16'd4999,  0, 21'd0,      16'd0);
        add_row(2, 16'd5000,  0, 21'd0,      16'd0);
        add_row(2, 16'd5001,  0, 21'd0,      16'd0);
        add_row(2, 16'd25000, 0, 21'd0,      16'd0);
        add_row(2, 16'd40000, 0, 21'd0,      16'd0);
        add_row(2, 16'hAAAA,  0, 21'd0,      16'd0);
        add_row(2, 16'h5555,  0, 21'd0,      16'd0);
        add_row(2, 16'hFFFF,  0, 21'd0,      16'd0);
        add_row(3, 16'hFFFF,  1, 21'd0,      16'd1000);
        add_row(3, 16'd20000, 1, 21'd0,      16'd1000);
        add_row(4, 16'hFFFF,  1, SIGNAL_MAX, 16'hFFFF);
        add_row(4, 16'd0,     1, 21'd0,      16'd65000);
        add_row(5, 16'hFFFF,  1, 21'd0,      16'd0);
        add_row(5, 16'd1001,  1, 21'd0,      16'd0);

        // Hold reset, then release it
        active_cfg = setting_table[0];
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table without idling
        cur_sel = 0;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].setting != cur_sel) begin
                wait_idle();
                cur_sel = directed_rows[i].setting;
                apply_setting(setting_table[cur_sel]);
            end
            send_sample(directed_rows[i].raw, directed_rows[i].typed, directed_rows[i].result);
        end

        // Random phases, each under its own setting and idling pattern
        for (phase = 0; phase < NUM_RANDOM_PHASES; phase++) begin
            wait_idle();
            case (phase % 4)
                0: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct  = 65;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 65;
                end
                default: begin
                    src_idle_pct  = 25;
                    snk_stall_pct = 25;
                end
            endcase
            if (phase == 0)
                apply_setting(setting_table[1]);
            else if (phase == 1)
                apply_setting(setting_table[5]);
            else
                apply_setting(random_setting());
            repeat (ITEMS_PER_PHASE) send_sample(random_sample(), 1'b0, none);
        end

        // Drain and report
        wait_idle();
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
